[sv/sfc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spring force package
// Shared types, widths and register indexes for the spring force pipeline.
// ----------------------------------------------------------------------------
package sfc_pkg;

  // Default width from which coordinates are sign extended.
  localparam int SFC_COORD_WIDTH = 32;

  // Fixed datapath widths.
  localparam int SFC_FIELD_W = 32;              // Q16.16 field
  localparam int SFC_CFG_W   = 31;              // configuration register width
  localparam int SFC_AD_W    = 32;              // |d| per axis
  localparam int SFC_SUM_W   = 66;              // sum of squares
  localparam int SFC_LEN_W   = 33;              // square root of the sum
  localparam int SFC_REM_W   = 36;              // square root partial remainder
  localparam int SFC_KS_W    = 64;              // k * |s|
  localparam int SFC_Q_W     = 32;              // quotient bits per axis
  localparam int SFC_SQRT_CELLS = SFC_SUM_W / 2;
  localparam int SFC_DIV_CELLS  = SFC_Q_W;

  localparam logic [SFC_CFG_W-1:0] SFC_K_RESET    = 31'd65536;
  localparam logic [SFC_CFG_W-1:0] SFC_REST_RESET = 31'd65536;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_SPRING_CONSTANT = 1'b0,
    REG_REST_LENGTH     = 1'b1
  } sfc_reg_e;

  // Request payload.
  typedef struct packed {
    logic signed [SFC_FIELD_W-1:0] pos_x;
    logic signed [SFC_FIELD_W-1:0] pos_y;
    logic signed [SFC_FIELD_W-1:0] pos_z;
    logic signed [SFC_FIELD_W-1:0] end_x;
    logic signed [SFC_FIELD_W-1:0] end_y;
    logic signed [SFC_FIELD_W-1:0] end_z;
  } sfc_req_t;

  // Result payload.
  typedef struct packed {
    logic signed [SFC_FIELD_W-1:0] force_x;
    logic signed [SFC_FIELD_W-1:0] force_y;
    logic signed [SFC_FIELD_W-1:0] force_z;
    logic                          zero_length;
    logic                          saturated;
  } sfc_res_t;

  // Per-request data that travels alongside the square root.
  typedef struct packed {
    logic [2:0][SFC_AD_W-1:0] ad;
    logic [2:0]               dpos;
    logic                     zero;
  } sfc_side_t;

  // Square root cell state.
  typedef struct packed {
    logic                   valid;
    logic [SFC_SUM_W-1:0]   rad;
    logic [SFC_REM_W-1:0]   rem;
    logic [SFC_LEN_W-1:0]   root;
    sfc_side_t              side;
  } sfc_sqrt_t;

  // Division cell state, three axes side by side.
  typedef struct packed {
    logic                          valid;
    logic [SFC_LEN_W-1:0]          len;
    logic [2:0][SFC_LEN_W-1:0]     r;
    logic [2:0][SFC_Q_W-1:0]       low;
    logic [2:0][SFC_Q_W-1:0]       q;
    logic [2:0]                    ov;
    logic [2:0]                    neg;
    logic                          zero;
  } sfc_div_t;

endpackage

[sv/sfc_sqrt_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Square root cell
// One digit step of the integer square root; retires two radicand bits.
// ----------------------------------------------------------------------------
module sfc_sqrt_cell import sfc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  sfc_sqrt_t cell_i,
  output sfc_sqrt_t cell_o
);

  sfc_sqrt_t            step_d;
  sfc_sqrt_t            cell_q;
  logic                 valid_q;
  logic [SFC_REM_W-1:0] cur;
  logic [SFC_REM_W-1:0] trial;
  logic                 take;

  // Bring down the next bit pair and try the next root bit.
  always_comb begin
    cur   = {cell_i.rem[SFC_REM_W-3:0], cell_i.rad[SFC_SUM_W-1 -: 2]};
    trial = SFC_REM_W'({cell_i.root, 2'b01});
    take  = (cur >= trial);
    step_d       = cell_i;
    step_d.rad   = {cell_i.rad[SFC_SUM_W-3:0], 2'b00};
    step_d.rem   = take ? (cur - trial) : cur;
    step_d.root  = {cell_i.root[SFC_LEN_W-2:0], take};
  end

  // The valid flag is reset; the payload is not.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cell_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    cell_q <= step_d;
  end

  always_comb begin
    cell_o       = cell_q;
    cell_o.valid = valid_q;
  end

endmodule

[sv/sfc_div_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Division cell
// One restoring division step on each of the three axes.
// ----------------------------------------------------------------------------
module sfc_div_cell import sfc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  sfc_div_t cell_i,
  output sfc_div_t cell_o
);

  sfc_div_t           step_d;
  sfc_div_t           cell_q;
  logic               valid_q;
  logic [SFC_LEN_W:0] cur [3];
  logic [2:0]         take;

  // Shift in one numerator bit per axis and subtract the length when it fits.
  always_comb begin
    step_d = cell_i;
    for (int i = 0; i < 3; i++) begin
      cur[i]  = {cell_i.r[i], cell_i.low[i][SFC_Q_W-1]};
      take[i] = (cur[i] >= {1'b0, cell_i.len});
      step_d.r[i]   = take[i] ? SFC_LEN_W'(cur[i] - {1'b0, cell_i.len})
                              : cur[i][SFC_LEN_W-1:0];
      step_d.low[i] = {cell_i.low[i][SFC_Q_W-2:0], 1'b0};
      step_d.q[i]   = {cell_i.q[i][SFC_Q_W-2:0], take[i]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cell_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    cell_q <= step_d;
  end

  always_comb begin
    cell_o       = cell_q;
    cell_o.valid = valid_q;
  end

endmodule

[sv/spring_force_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spring force core
// Hooke's law force on a particle from a spring to another end, Q16.16.
// ----------------------------------------------------------------------------
//   Channel   Ports                                   Direction
//   request   start_i, busy_o, req_i                  in
//   result    done_o, res_o                           out
//   config    cfg_we_i, cfg_idx_i, cfg_wdata_i        in
//
// A request is taken in every cycle; busy_o stays low.
// Each result passes through three front stages, a row of 33 square root
// cells, four multiply stages, a row of 32 division cells and the output
// register.
// Reset clears all valid flags and loads the default registers.
// Results are shown for one cycle on done_o and cannot be held off.
// ----------------------------------------------------------------------------
module spring_force_core import sfc_pkg::*; #(
  parameter int COORD_WIDTH = SFC_COORD_WIDTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  sfc_req_t             req_i,
  output logic                 busy_o,
  output logic                 done_o,
  output sfc_res_t             res_o,
  input  logic                 cfg_we_i,
  input  logic [0:0]           cfg_idx_i,
  input  logic [SFC_CFG_W-1:0] cfg_wdata_i
);

  localparam int SextW   = (COORD_WIDTH < SFC_FIELD_W) ? COORD_WIDTH : SFC_FIELD_W;
  localparam int Latency = 3 + SFC_SQRT_CELLS + 4 + SFC_DIV_CELLS + 1;

  // Configuration registers.
  logic [SFC_CFG_W-1:0] k_q, rest_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q    <= SFC_K_RESET;
      rest_q <= SFC_REST_RESET;
    end else if (cfg_we_i) begin
      unique case (sfc_reg_e'(cfg_idx_i))
        REG_SPRING_CONSTANT: k_q    <= cfg_wdata_i;
        REG_REST_LENGTH:     rest_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign busy_o = 1'b0;

  // Stage A: differences and their magnitudes.
  logic signed [SFC_FIELD_W:0] pe [3];
  logic signed [SFC_FIELD_W:0] ee [3];
  logic signed [SFC_FIELD_W:0] dd [3];
  sfc_side_t side_a_d, side_a_q;
  logic      va_q, vb_q, vc_q;

  always_comb begin
    pe[0] = (SFC_FIELD_W+1)'($signed(req_i.pos_x[SextW-1:0]));
    pe[1] = (SFC_FIELD_W+1)'($signed(req_i.pos_y[SextW-1:0]));
    pe[2] = (SFC_FIELD_W+1)'($signed(req_i.pos_z[SextW-1:0]));
    ee[0] = (SFC_FIELD_W+1)'($signed(req_i.end_x[SextW-1:0]));
    ee[1] = (SFC_FIELD_W+1)'($signed(req_i.end_y[SextW-1:0]));
    ee[2] = (SFC_FIELD_W+1)'($signed(req_i.end_z[SextW-1:0]));
    side_a_d = '0;
    for (int i = 0; i < 3; i++) begin
      dd[i] = pe[i] - ee[i];
      side_a_d.ad[i]   = dd[i][SFC_FIELD_W] ? SFC_AD_W'(-dd[i]) : SFC_AD_W'(dd[i]);
      side_a_d.dpos[i] = !dd[i][SFC_FIELD_W] && (dd[i] != '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      va_q <= start_i;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  // Stage B: squares. Stage C: sum of squares.
  logic [2:0][2*SFC_AD_W-1:0] sq_q;
  sfc_side_t                  side_b_q, side_c_q;
  sfc_side_t                  side_c_d;
  logic [SFC_SUM_W-1:0]       sum_q;
  logic [SFC_SUM_W-1:0]       sum_d;

  assign sum_d = SFC_SUM_W'(sq_q[0]) + SFC_SUM_W'(sq_q[1]) + SFC_SUM_W'(sq_q[2]);

  // The coincident-ends flag joins the side data as the sum is formed.
  always_comb begin
    side_c_d      = side_b_q;
    side_c_d.zero = (sum_d == '0);
  end

  always_ff @(posedge clk_i) begin
    side_a_q <= side_a_d;
    for (int i = 0; i < 3; i++) begin
      sq_q[i] <= side_a_q.ad[i] * side_a_q.ad[i];
    end
    side_b_q <= side_a_q;
    sum_q    <= sum_d;
    side_c_q <= side_c_d;
  end

  // Square root row.
  sfc_sqrt_t sq_chain [SFC_SQRT_CELLS+1];

  always_comb begin
    sq_chain[0].valid = vc_q;
    sq_chain[0].rad   = sum_q;
    sq_chain[0].rem   = '0;
    sq_chain[0].root  = '0;
    sq_chain[0].side  = side_c_q;
  end

  for (genvar g = 0; g < SFC_SQRT_CELLS; g++) begin : g_sqrt
    sfc_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cell_i (sq_chain[g]),
      .cell_o (sq_chain[g+1])
    );
  end

  // Stage D: stretch against the rest length.
  sfc_sqrt_t                sq_end;
  logic signed [SFC_LEN_W:0] s_d;
  logic [SFC_LEN_W-1:0]      len_d_q, len_e_q, len_f_q;
  logic [SFC_LEN_W-1:0]      as_q;
  logic                      spos_d_q, spos_e_q, spos_f_q;
  sfc_side_t                 side_d_q, side_e_q, side_f_q;
  logic                      vd_q, ve_q, vf_q, vg_q;

  assign sq_end = sq_chain[SFC_SQRT_CELLS];
  assign s_d    = $signed({1'b0, sq_end.root}) - $signed({3'b000, rest_q});

  // Stage E: k * |s|. Stage F: split products per axis.
  logic [SFC_KS_W-1:0]          ks_q;
  logic [2:0][SFC_KS_W-1:0]     pl_q, ph_q;
  logic [SFC_KS_W+SFC_AD_W-1:0] num [3];
  sfc_div_t                     div_in_d, div_in_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
      ve_q <= 1'b0;
      vf_q <= 1'b0;
      vg_q <= 1'b0;
    end else begin
      vd_q <= sq_end.valid;
      ve_q <= vd_q;
      vf_q <= ve_q;
      vg_q <= vf_q;
    end
  end

  always_ff @(posedge clk_i) begin
    len_d_q  <= sq_end.root;
    spos_d_q <= (s_d > 0);
    as_q     <= s_d[SFC_LEN_W] ? SFC_LEN_W'(-s_d) : SFC_LEN_W'(s_d);
    side_d_q <= sq_end.side;
    ks_q     <= SFC_KS_W'(k_q * as_q);
    len_e_q  <= len_d_q;
    spos_e_q <= spos_d_q;
    side_e_q <= side_d_q;
    for (int i = 0; i < 3; i++) begin
      pl_q[i] <= ks_q[SFC_KS_W/2-1:0] * side_e_q.ad[i];
      ph_q[i] <= ks_q[SFC_KS_W-1:SFC_KS_W/2] * side_e_q.ad[i];
    end
    len_f_q  <= len_e_q;
    spos_f_q <= spos_e_q;
    side_f_q <= side_e_q;
    div_in_q <= div_in_d;
  end

  // Stage G: full numerator, drop the 2^16 scale, check for quotient overflow.
  always_comb begin
    div_in_d       = '0;
    div_in_d.len   = len_f_q;
    div_in_d.zero  = side_f_q.zero;
    for (int i = 0; i < 3; i++) begin
      num[i] = {ph_q[i], 32'h0} + (SFC_KS_W+SFC_AD_W)'(pl_q[i]);
      div_in_d.ov[i]  = (num[i][95:48] >= 48'(len_f_q));
      div_in_d.r[i]   = num[i][48+SFC_LEN_W-1:48];
      div_in_d.low[i] = num[i][47:16];
      div_in_d.neg[i] = (spos_f_q == side_f_q.dpos[i]);
    end
  end

  // Division row.
  sfc_div_t dv_chain [SFC_DIV_CELLS+1];

  always_comb begin
    dv_chain[0]       = div_in_q;
    dv_chain[0].valid = vg_q;
  end

  for (genvar g = 0; g < SFC_DIV_CELLS; g++) begin : g_div
    sfc_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cell_i (dv_chain[g]),
      .cell_o (dv_chain[g+1])
    );
  end

  // Output stage: sign, saturation and the coincident-ends case.
  sfc_div_t                dv_end;
  logic [2:0][SFC_Q_W-1:0] f_d;
  logic [2:0]              sat_d;
  sfc_res_t                res_d, res_q;
  logic                    done_q;

  assign dv_end = dv_chain[SFC_DIV_CELLS];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dv_end.neg[i]) begin
        sat_d[i] = dv_end.ov[i] || (dv_end.q[i] > 32'h8000_0000);
        f_d[i]   = sat_d[i] ? 32'h8000_0000 : (~dv_end.q[i] + 32'd1);
      end else begin
        sat_d[i] = dv_end.ov[i] || dv_end.q[i][SFC_Q_W-1];
        f_d[i]   = sat_d[i] ? 32'h7FFF_FFFF : dv_end.q[i];
      end
    end
    res_d.force_x     = dv_end.zero ? '0 : f_d[0];
    res_d.force_y     = dv_end.zero ? '0 : f_d[1];
    res_d.force_z     = dv_end.zero ? '0 : f_d[2];
    res_d.zero_length = dv_end.zero;
    res_d.saturated   = !dv_end.zero && (sat_d != 3'b000);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dv_end.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  // Every result comes from a request taken a fixed time before.
  a_done_has_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, Latency))
    else $error("result without a matching request");

  // Every request yields a result after the fixed latency.
  a_request_gives_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> ##Latency done_o)
    else $error("request lost in the pipeline");

  // Coincident ends give zero force and never report clipping.
  a_zero_force: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.zero_length) |->
      (res_o.force_x == '0 && res_o.force_y == '0 && res_o.force_z == '0
       && !res_o.saturated))
    else $error("zero length result carries force");

  // A clipped result has at least one component at a rail.
  a_sat_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.saturated) |->
      (res_o.force_x == 32'h7FFF_FFFF || res_o.force_x == 32'h8000_0000 ||
       res_o.force_y == 32'h7FFF_FFFF || res_o.force_y == 32'h8000_0000 ||
       res_o.force_z == 32'h7FFF_FFFF || res_o.force_z == 32'h8000_0000))
    else $error("saturation flag without a clipped component");

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spring force core testbench
// Drives position requests through the spring force pipeline under several
// stiffness and rest length settings, predicts each Hooke's law force in
// wide integer arithmetic and checks every result field in order.
// ----------------------------------------------------------------------------
module tb_top;
  import sfc_pkg::*;

  localparam int SETTLE_CYCLES = 90;
  localparam int CYCLE_LIMIT   = 400000;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start_i = 1'b0;
  sfc_req_t             req_i = '0;
  logic                 busy_o;
  logic                 done_o;
  sfc_res_t             res_o;
  logic                 cfg_we_i = 1'b0;
  logic [0:0]           cfg_idx_i = REG_SPRING_CONSTANT;
  logic [SFC_CFG_W-1:0] cfg_wdata_i = '0;

  // Model copy of the registers.
  logic [SFC_CFG_W-1:0] stiffness = SFC_K_RESET;
  logic [SFC_CFG_W-1:0] rest_len  = SFC_REST_RESET;

  sfc_req_t pending_req_q[$];
  sfc_res_t force_due_q[$];
  int       fail_count = 0;
  int       cycle_count = 0;
  bit       no_gaps = 1'b0;

  spring_force_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .req_i       (req_i),
    .busy_o      (busy_o),
    .done_o      (done_o),
    .res_o       (res_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Hooke's law force with floor square root and truncating division.
  function automatic sfc_res_t spring_force(sfc_req_t r);
    logic signed [31:0]  pp[3];
    logic signed [31:0]  ee[3];
    logic signed [32:0]  d[3];
    logic [127:0]        ad[3];
    logic [127:0]        sq_sum, lo, hi, mid, len, ks, num, den, q;
    logic signed [63:0]  s;
    logic [63:0]         as;
    logic                neg;
    sfc_res_t            res;
    logic signed [31:0]  f[3];
    pp[0] = r.pos_x; pp[1] = r.pos_y; pp[2] = r.pos_z;
    ee[0] = r.end_x; ee[1] = r.end_y; ee[2] = r.end_z;
    sq_sum = '0;
    res = '0;
    for (int i = 0; i < 3; i++) begin
      d[i] = $signed({pp[i][31], pp[i]}) - $signed({ee[i][31], ee[i]});
      ad[i] = d[i] < 0 ? 128'(-d[i]) : 128'(d[i]);
      ad[i] = ad[i] & 128'h1_FFFF_FFFF;
      sq_sum = sq_sum + ad[i] * ad[i];
    end
    if (sq_sum == 0) begin
      res.zero_length = 1'b1;
      return res;
    end
    lo = '0;
    hi = 128'd1 << 34;
    while (lo < hi) begin
      mid = lo + ((hi - lo + 1) >> 1);
      if (mid * mid <= sq_sum) lo = mid;
      else hi = mid - 1;
    end
    len = lo;
    s = $signed(64'(len)) - $signed(64'(rest_len));
    as = s < 0 ? 64'(-s) : 64'(s);
    ks = 128'(stiffness) * 128'(as);
    den = len << 16;
    for (int i = 0; i < 3; i++) begin
      num = ks * ad[i];
      q = num / den;
      neg = ((s > 0) == (d[i] > 0)) && s != 0 && d[i] != 0;
      if (neg) begin
        if (q > 128'h8000_0000) begin
          f[i] = 32'h8000_0000;
          res.saturated = 1'b1;
        end else begin
          f[i] = -q[31:0];
        end
      end else begin
        if (q > 128'h7FFF_FFFF) begin
          f[i] = 32'h7FFF_FFFF;
          res.saturated = 1'b1;
        end else begin
          f[i] = q[31:0];
        end
      end
    end
    res.force_x = f[0];
    res.force_y = f[1];
    res.force_z = f[2];
    return res;
  endfunction

  // Random request: mostly nearby ends, some fully random, some aligned on x and some coincident.
  function automatic sfc_req_t random_req();
    sfc_req_t r;
    int       mode;
    int       span;
    r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    mode = $urandom_range(0, 9);
    span = $urandom_range(4, 24);
    if (mode < 6) begin
      r.pos_x = r.end_x + ($signed($urandom) >>> (32 - span));
      r.pos_y = r.end_y + ($signed($urandom) >>> (32 - span));
      r.pos_z = r.end_z + ($signed($urandom) >>> (32 - span));
    end else if (mode == 6) begin
      r.pos_y = r.end_y;
      r.pos_z = r.end_z;
      r.pos_x = r.end_x + ($signed($urandom) >>> (32 - span));
    end else if (mode == 7) begin
      r.pos_x = r.end_x;
      r.pos_y = r.end_y;
      r.pos_z = r.end_z;
    end
    return r;
  endfunction

  task automatic write_reg(sfc_reg_e idx, logic [SFC_CFG_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_SPRING_CONSTANT) stiffness = value;
    else rest_len = value;
  endtask

  // Append one request to the pending list.
  task automatic queue_req(sfc_req_t r);
    pending_req_q = {pending_req_q, r};
  endtask

  // Let every request in flight come out before the settings change.
  task automatic drain();
    while (pending_req_q.size() != 0 || force_due_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic queue_random(int count);
    repeat (count) queue_req(random_req());
  endtask

  // Request driver: changes inputs on the falling edge.
  always @(negedge clk_i) begin
    if (rst_ni && pending_req_q.size() != 0 &&
        (no_gaps || $urandom_range(0, 99) >= 13)) begin
      start_i <= 1'b1;
      req_i   <= pending_req_q[0];
    end else begin
      start_i <= 1'b0;
    end
  end

  // Accept requests and check results on the rising edge.
  always @(posedge clk_i) begin
    sfc_res_t want;
    if (rst_ni && start_i && !busy_o) begin
      force_due_q = {force_due_q, spring_force(req_i)};
      void'(pending_req_q.pop_front());
    end
    if (rst_ni && done_o) begin
      if (force_due_q.size() == 0) begin
        $error("result with no request outstanding");
        fail_count++;
      end else begin
        want = force_due_q.pop_front();
        if (res_o.force_x !== want.force_x) begin
          $error("force_x expected %0d got %0d", want.force_x, res_o.force_x);
          fail_count++;
        end
        if (res_o.force_y !== want.force_y) begin
          $error("force_y expected %0d got %0d", want.force_y, res_o.force_y);
          fail_count++;
        end
        if (res_o.force_z !== want.force_z) begin
          $error("force_z expected %0d got %0d", want.force_z, res_o.force_z);
          fail_count++;
        end
        if (res_o.zero_length !== want.zero_length) begin
          $error("zero_length expected %0b got %0b", want.zero_length,
                 res_o.zero_length);
          fail_count++;
        end
        if (res_o.saturated !== want.saturated) begin
          $error("saturated expected %0b got %0b", want.saturated, res_o.saturated);
          fail_count++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // Stimulus sequence.
  initial begin
    sfc_req_t r;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed requests under reset settings.
    r = '0;
    queue_req(r);                                       // coincident ends at origin
    r = {32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
         32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000};
    queue_req(r);                                       // widest separation
    queue_req({r.end_x, r.end_y, r.end_z, r.pos_x, r.pos_y, r.pos_z});
    r = {32'sh0001_0000, 32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh0};
    queue_req(r);                                       // exactly at rest length
    r = {32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh0001_0000};
    queue_req(r);                                       // at rest length, negative axis
    r = {32'sh0000_8000, 32'sh0000_8000, 32'sh0, 32'sh0, 32'sh0, 32'sh0};
    queue_req(r);                                       // compressed
    r = {32'sh0005_0000, -32'sh0003_0000, 32'sh0002_0000, 32'sh0, 32'sh0, 32'sh0};
    queue_req(r);                                       // stretched, mixed signs
    r = {32'sh0, 32'sh0, 32'sh1, 32'sh0, 32'sh0, 32'sh0};
    queue_req(r);                                       // one LSB apart
    r = {32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
         32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000};
    queue_req(r);                                       // coincident at the extremes
    r = {32'shFFFF_FFFF, 32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh0};
    queue_req(r);
    queue_random(230);
    drain();

    // Stiffest spring with zero rest length: saturation is common.
    write_reg(REG_SPRING_CONSTANT, {SFC_CFG_W{1'b1}});
    write_reg(REG_REST_LENGTH, '0);
    r = {32'sh7FFF_FFFF, 32'sh0, 32'sh0, 32'sh8000_0000, 32'sh0, 32'sh0};
    queue_req(r);
    queue_req({r.end_x, r.end_y, r.end_z, r.pos_x, r.pos_y, r.pos_z});
    queue_req('0);
    queue_random(230);
    drain();

    // No stiffness, then a power-of-two stiffness, longest rest length, requests back to back.
    no_gaps = 1'b1;
    write_reg(REG_SPRING_CONSTANT, '0);
    write_reg(REG_REST_LENGTH, {SFC_CFG_W{1'b1}});
    queue_random(120);
    drain();
    write_reg(REG_SPRING_CONSTANT, 31'd65536 << $urandom_range(0, 14));
    queue_random(120);
    drain();
    no_gaps = 1'b0;

    // Random settings.
    repeat (2) begin
      write_reg(REG_SPRING_CONSTANT, SFC_CFG_W'($urandom));
      write_reg(REG_REST_LENGTH, SFC_CFG_W'($urandom >> $urandom_range(0, 31)));
      queue_random(230);
      drain();
    end

    if (fail_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
